/* rtl/ktq_pkg.sv */
package ktq_pkg;

    // request action codes
    typedef enum logic [2:0] {
        ACT_ROW_WR    = 3'd0,
        ACT_COL_WR    = 3'd1,
        ACT_CELL_WR   = 3'd2,
        ACT_GET       = 3'd3,
        ACT_CHECK_ROW = 3'd4,
        ACT_CHECK_COL = 3'd5,
        ACT_FIND      = 3'd6
    } action_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] CFG_TABLE_LOADED = 2'd2;

    // column kinds
    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_NUMERIC = 2'd1;
    localparam logic [1:0] KIND_STRING  = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // find miss value
    localparam logic [31:0] NOT_FOUND = 32'hFFFF_FFFF;

    // fixed field widths
    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 4;
    localparam int KEY_W     = 32;
    localparam int CFG_W     = 7;

    // which table a scan walks
    typedef enum logic [1:0] {
        SCAN_ROW  = 2'd0,
        SCAN_COL  = 2'd1,
        SCAN_FIND = 2'd2
    } scan_mode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ROW_SCAN,
        ST_COL_SCAN,
        ST_CELL_READ,
        ST_CELL_WAIT,
        ST_FIND_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       dispatch;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       scan_run;
        logic       row_hit_take;
        logic       col_hit_take;
        logic       get_take;
        logic       find_take;
        logic       emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       loaded;
        logic       scan_hit;
        logic       scan_end;
        logic       col_numeric;
        logic       out_free;
    } status_t;

endpackage

/* rtl/keyed_table_query_top.sv */
// channel   direction  handshake          payload
// request   in         s_valid / s_ready  s_action .. s_search_value
// result    out        m_valid / m_ready  m_result_ok, m_result_value, m_column_kind
// config    in         cfg_wr_en          cfg_index, cfg_wdata
//
// one request at a time; the key and cell memories are scanned one entry per
// cycle through a single registered read port each
// reset is synchronous, active low; it clears the controller, the scan counter,
// the output valid and the configuration registers, not the table memories
// a new request is taken while a result waits in the output register; the next
// result then holds in the controller until m_ready frees the output register
module keyed_table_query_top #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [ktq_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_action,
    input  logic [ktq_pkg::ROW_IDX_W-1:0]    s_row_index,
    input  logic [ktq_pkg::COL_IDX_W-1:0]    s_column_index,
    input  logic signed [ktq_pkg::KEY_W-1:0] s_row_key,
    input  logic signed [ktq_pkg::KEY_W-1:0] s_column_key,
    input  logic [1:0]                       s_column_type,
    input  logic signed [ktq_pkg::KEY_W-1:0] s_cell_value,
    input  logic signed [ktq_pkg::KEY_W-1:0] s_search_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_ok,
    output logic signed [ktq_pkg::KEY_W-1:0] m_result_value,
    output logic [1:0]                       m_column_kind
);

    ktq_pkg::cmd_t    cmd;
    ktq_pkg::status_t status;

    // sequencer
    ktq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table storage, scan engine and result path
    ktq_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .s_row_key      (s_row_key),
        .s_column_key   (s_column_key),
        .s_column_type  (s_column_type),
        .s_cell_value   (s_cell_value),
        .s_search_value (s_search_value),
        .cmd            (cmd),
        .status         (status),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_ok    (m_result_ok),
        .m_result_value (m_result_value),
        .m_column_kind  (m_column_kind)
    );

endmodule

/* rtl/ktq_ctrl.sv */
module ktq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ktq_pkg::status_t status,
    output ktq_pkg::cmd_t    cmd
);

    ktq_pkg::state_t state_reg;
    ktq_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ktq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.scan_mode = ktq_pkg::SCAN_ROW;
        s_ready       = 1'b0;
        unique case (state_reg)
            ktq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ktq_pkg::ST_DISPATCH;
                end
            end
            ktq_pkg::ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                state_next   = ktq_pkg::ST_RESULT;
                if (status.loaded) begin
                    case (status.action) inside
                        ktq_pkg::ACT_GET, ktq_pkg::ACT_CHECK_ROW: begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = ktq_pkg::SCAN_ROW;
                            state_next     = ktq_pkg::ST_ROW_SCAN;
                        end
                        ktq_pkg::ACT_CHECK_COL, ktq_pkg::ACT_FIND: begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = ktq_pkg::SCAN_COL;
                            state_next     = ktq_pkg::ST_COL_SCAN;
                        end
                        default: begin
                            state_next = ktq_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            ktq_pkg::ST_ROW_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.scan_hit) begin
                    cmd.row_hit_take = 1'b1;
                    if (status.action == ktq_pkg::ACT_GET) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = ktq_pkg::SCAN_COL;
                        state_next     = ktq_pkg::ST_COL_SCAN;
                    end else begin
                        state_next = ktq_pkg::ST_RESULT;
                    end
                end else if (status.scan_end) begin
                    state_next = ktq_pkg::ST_RESULT;
                end
            end
            ktq_pkg::ST_COL_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.scan_hit) begin
                    cmd.col_hit_take = 1'b1;
                    state_next       = ktq_pkg::ST_RESULT;
                    if (status.col_numeric) begin
                        if (status.action == ktq_pkg::ACT_GET) begin
                            state_next = ktq_pkg::ST_CELL_READ;
                        end else if (status.action == ktq_pkg::ACT_FIND) begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = ktq_pkg::SCAN_FIND;
                            state_next     = ktq_pkg::ST_FIND_SCAN;
                        end
                    end
                end else if (status.scan_end) begin
                    state_next = ktq_pkg::ST_RESULT;
                end
            end
            ktq_pkg::ST_CELL_READ: begin
                state_next = ktq_pkg::ST_CELL_WAIT;
            end
            ktq_pkg::ST_CELL_WAIT: begin
                cmd.get_take = 1'b1;
                state_next   = ktq_pkg::ST_RESULT;
            end
            ktq_pkg::ST_FIND_SCAN: begin
                cmd.scan_run = 1'b1;
                cmd.scan_mode = ktq_pkg::SCAN_FIND;
                if (status.scan_hit) begin
                    cmd.find_take = 1'b1;
                    state_next    = ktq_pkg::ST_RESULT;
                end else if (status.scan_end) begin
                    state_next = ktq_pkg::ST_RESULT;
                end
            end
            ktq_pkg::ST_RESULT: begin
                cmd.emit = 1'b1;
                if (status.out_free) begin
                    state_next = ktq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ktq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ktq_datapath.sv */
module ktq_datapath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [ktq_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [2:0]                          s_action,
    input  logic [ktq_pkg::ROW_IDX_W-1:0]       s_row_index,
    input  logic [ktq_pkg::COL_IDX_W-1:0]       s_column_index,
    input  logic signed [ktq_pkg::KEY_W-1:0]    s_row_key,
    input  logic signed [ktq_pkg::KEY_W-1:0]    s_column_key,
    input  logic [1:0]                          s_column_type,
    input  logic signed [ktq_pkg::KEY_W-1:0]    s_cell_value,
    input  logic signed [ktq_pkg::KEY_W-1:0]    s_search_value,
    input  ktq_pkg::cmd_t                       cmd,
    output ktq_pkg::status_t                    status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic                                m_result_ok,
    output logic signed [ktq_pkg::KEY_W-1:0]    m_result_value,
    output logic [1:0]                          m_column_kind
);

    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SCAN_MAX = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
    localparam int CNT_W    = $clog2(SCAN_MAX + 1);
    localparam int RX_W     = 13;
    localparam int CX_W     = 9;

    // configuration registers
    logic [6:0] row_count_reg;
    logic [4:0] column_count_reg;
    logic       table_loaded_reg;

    // latched request
    logic [2:0]                       item_action_reg;
    logic [ktq_pkg::ROW_IDX_W-1:0]    item_row_index_reg;
    logic [ktq_pkg::COL_IDX_W-1:0]    item_column_index_reg;
    logic [ktq_pkg::KEY_W-1:0]        item_row_key_reg;
    logic [ktq_pkg::KEY_W-1:0]        item_column_key_reg;
    logic [1:0]                       item_column_type_reg;
    logic [ktq_pkg::KEY_W-1:0]        item_cell_value_reg;
    logic [ktq_pkg::KEY_W-1:0]        item_search_value_reg;

    // table storage
    logic [ktq_pkg::KEY_W-1:0] row_key_mem [MAX_ROWS];
    logic [ktq_pkg::KEY_W-1:0] col_key_mem [MAX_COLUMNS];
    logic [1:0]                col_type_mem [MAX_COLUMNS];
    logic [ktq_pkg::KEY_W-1:0] cell_mem [MAX_ROWS][MAX_COLUMNS];

    logic [ktq_pkg::KEY_W-1:0] row_key_rdata_reg;
    logic [ktq_pkg::KEY_W-1:0] col_key_rdata_reg;
    logic [1:0]                col_type_rdata_reg;
    logic [ktq_pkg::KEY_W-1:0] cell_rdata_reg;

    // scan engine
    ktq_pkg::scan_mode_t scan_mode_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                scan_valid_reg;
    logic [RW-1:0]       row_found_reg;
    logic [CW-1:0]       col_found_reg;

    // result and output stage
    logic                      res_ok_reg;
    logic [ktq_pkg::KEY_W-1:0] res_value_reg;
    logic [1:0]                res_kind_reg;
    logic                      m_valid_reg;
    logic                      m_ok_reg;
    logic [ktq_pkg::KEY_W-1:0] m_value_reg;
    logic [1:0]                m_kind_reg;

    logic [RX_W-1:0]  row_index_ext;
    logic [CX_W-1:0]  col_index_ext;
    logic [RW-1:0]    wr_row;
    logic [CW-1:0]    wr_col;
    logic             row_idx_ok;
    logic             col_idx_ok;
    logic             write_ok;
    logic             row_key_we;
    logic             col_we;
    logic             cell_we;
    logic [1:0]       wr_kind;
    logic [CNT_W-1:0] rows_used;
    logic [CNT_W-1:0] cols_used;
    logic [CNT_W-1:0] scan_limit;
    logic             scan_issue;
    logic             scan_match;
    logic [RW-1:0]    cell_rd_row;
    logic             out_free;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
            table_loaded_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ktq_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                ktq_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_wdata[4:0];
                ktq_pkg::CFG_TABLE_LOADED: table_loaded_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_action_reg       <= s_action;
            item_row_index_reg    <= s_row_index;
            item_column_index_reg <= s_column_index;
            item_row_key_reg      <= s_row_key;
            item_column_key_reg   <= s_column_key;
            item_column_type_reg  <= s_column_type;
            item_cell_value_reg   <= s_cell_value;
            item_search_value_reg <= s_search_value;
        end
    end

    // write decode
    assign row_index_ext = RX_W'(item_row_index_reg);
    assign col_index_ext = CX_W'(item_column_index_reg);
    assign wr_row        = row_index_ext[RW-1:0];
    assign wr_col        = col_index_ext[CW-1:0];
    assign row_idx_ok    = 32'(item_row_index_reg) < MAX_ROWS;
    assign col_idx_ok    = 32'(item_column_index_reg) < MAX_COLUMNS;
    assign wr_kind       = (item_column_type_reg == ktq_pkg::KIND_INVALID) ?
                           ktq_pkg::KIND_OTHER : item_column_type_reg;

    always_comb begin
        write_ok = 1'b0;
        case (item_action_reg)
            ktq_pkg::ACT_ROW_WR:  write_ok = row_idx_ok;
            ktq_pkg::ACT_COL_WR:  write_ok = col_idx_ok;
            ktq_pkg::ACT_CELL_WR: write_ok = row_idx_ok && col_idx_ok;
            default:              write_ok = 1'b0;
        endcase
    end

    assign row_key_we = cmd.dispatch && write_ok && (item_action_reg == ktq_pkg::ACT_ROW_WR);
    assign col_we     = cmd.dispatch && write_ok && (item_action_reg == ktq_pkg::ACT_COL_WR);
    assign cell_we    = cmd.dispatch && write_ok && (item_action_reg == ktq_pkg::ACT_CELL_WR);

    // scan limits, counts above the table size act as the table size
    assign rows_used = (32'(row_count_reg) > MAX_ROWS) ?
                       CNT_W'(MAX_ROWS) : CNT_W'(row_count_reg);
    assign cols_used = (32'(column_count_reg) > MAX_COLUMNS) ?
                       CNT_W'(MAX_COLUMNS) : CNT_W'(column_count_reg);
    assign scan_limit = (scan_mode_reg == ktq_pkg::SCAN_COL) ? cols_used : rows_used;
    assign scan_issue = cmd.scan_run && (scan_cnt_reg < scan_limit);

    // scan counter, one read issued per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg  <= ktq_pkg::SCAN_ROW;
            scan_cnt_reg   <= '0;
            scan_valid_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            scan_mode_reg  <= cmd.scan_mode;
            scan_cnt_reg   <= '0;
            scan_valid_reg <= 1'b0;
        end else begin
            scan_valid_reg <= scan_issue;
            if (scan_issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_cnt_reg;
    end

    // row key memory
    always_ff @(posedge aclk) begin
        if (row_key_we) begin
            row_key_mem[wr_row] <= item_row_key_reg;
        end
        row_key_rdata_reg <= row_key_mem[scan_cnt_reg[RW-1:0]];
    end

    // column key and kind memories
    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_key_mem[wr_col]  <= item_column_key_reg;
            col_type_mem[wr_col] <= wr_kind;
        end
        col_key_rdata_reg  <= col_key_mem[scan_cnt_reg[CW-1:0]];
        col_type_rdata_reg <= col_type_mem[scan_cnt_reg[CW-1:0]];
    end

    // cell memory
    assign cell_rd_row = (scan_mode_reg == ktq_pkg::SCAN_FIND) ?
                         scan_cnt_reg[RW-1:0] : row_found_reg;

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[wr_row][wr_col] <= item_cell_value_reg;
        end
        cell_rdata_reg <= cell_mem[cell_rd_row][col_found_reg];
    end

    // compare the entry read last cycle
    always_comb begin
        case (scan_mode_reg)
            ktq_pkg::SCAN_ROW:  scan_match = row_key_rdata_reg == item_row_key_reg;
            ktq_pkg::SCAN_COL:  scan_match = col_key_rdata_reg == item_column_key_reg;
            ktq_pkg::SCAN_FIND: scan_match = cell_rdata_reg == item_search_value_reg;
            default:            scan_match = 1'b0;
        endcase
    end

    // positions of the matched row and column
    always_ff @(posedge aclk) begin
        if (cmd.row_hit_take) begin
            row_found_reg <= scan_idx_reg[RW-1:0];
        end
        if (cmd.col_hit_take) begin
            col_found_reg <= scan_idx_reg[CW-1:0];
        end
    end

    // result build
    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            res_ok_reg    <= write_ok;
            res_value_reg <= (item_action_reg == ktq_pkg::ACT_FIND) ? ktq_pkg::NOT_FOUND : '0;
            res_kind_reg  <= ktq_pkg::KIND_OTHER;
        end else if (cmd.row_hit_take) begin
            res_ok_reg <= item_action_reg == ktq_pkg::ACT_CHECK_ROW;
        end else if (cmd.col_hit_take) begin
            if (item_action_reg == ktq_pkg::ACT_CHECK_COL) begin
                res_ok_reg   <= 1'b1;
                res_kind_reg <= col_type_rdata_reg;
            end
        end else if (cmd.get_take) begin
            res_ok_reg    <= 1'b1;
            res_value_reg <= cell_rdata_reg;
        end else if (cmd.find_take) begin
            res_ok_reg    <= 1'b1;
            res_value_reg <= row_key_rdata_reg;
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit && out_free) begin
            m_ok_reg    <= res_ok_reg;
            m_value_reg <= res_value_reg;
            m_kind_reg  <= res_kind_reg;
        end
    end

    // status to controller
    assign status.action      = item_action_reg;
    assign status.loaded      = table_loaded_reg;
    assign status.scan_hit    = scan_valid_reg && scan_match;
    assign status.scan_end    = !scan_valid_reg && !(scan_cnt_reg < scan_limit);
    assign status.col_numeric = col_type_rdata_reg == ktq_pkg::KIND_NUMERIC;
    assign status.out_free    = out_free;

    assign m_valid        = m_valid_reg;
    assign m_result_ok    = m_ok_reg;
    assign m_result_value = m_value_reg;
    assign m_column_kind  = m_kind_reg;

endmodule
